@@ sv/tdpt_pkg.sv @@
// Shared types for the trial-division prime test: controller states and control structs.
package tdpt_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } tdpt_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch request value, reset divisor to three
    logic div_start;  // clear remainder, reload dividend and bit counter
    logic div_step;   // one restoring-division bit
    logic advance;    // move to the next odd divisor
    logic set_flag;   // write the result flag
    logic flag_val;   // value for the result flag
  } tdpt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic below_two;  // value is zero or one
    logic even;       // value is even
    logic is_two;     // value is exactly two
    logic bound_hit;  // divisor squared exceeds value
    logic div_last;   // current division step is the last
    logic rem_zero;   // remainder is zero
  } tdpt_status_t;

endpackage

@@ sv/trial_division_prime_test.sv @@
// Trial-division prime test: one request in, one value echo and prime flag out.
// Values below three or even are settled in the check state; an odd value is tried against
// odd divisors from three until one divides it or the divisor squared exceeds it, with a
// bit-serial restoring remainder of one bit per cycle for each divisor.
// Throughput: one request at a time; busy is low only in idle and high from check through the done cycle.
// Results are shown for one cycle with done high; the receiver cannot stall.
// Reset (synchronous, active high) returns the controller to idle; data registers are not cleared.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] number,
  output logic                  busy,
  output logic                  done,
  output logic [VALUE_BITS-1:0] tested_number,
  output logic                  prime_flag
);

  tdpt_cmd_t    cmd;
  tdpt_status_t status;

  tdpt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  tdpt_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .number        (number),
    .cmd           (cmd),
    .status        (status),
    .tested_number (tested_number),
    .prime_flag    (prime_flag)
  );

endmodule

@@ sv/tdpt_datapath.sv @@
// Datapath: value register, odd divisor and its square, bit-serial remainder unit.
module tdpt_datapath import tdpt_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic [VALUE_BITS-1:0] number,
  input  tdpt_cmd_t             cmd,
  output tdpt_status_t          status,
  output logic [VALUE_BITS-1:0] tested_number,
  output logic                  prime_flag
);

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int SW = VALUE_BITS + 2;

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] divisor;
  logic [SW-1:0]         div_sq;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] dividend;
  logic [CW-1:0]         cnt;
  logic                  flag;

  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   shifted;

  // One restoring-division step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem, dividend[VALUE_BITS-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value   <= number;
      divisor <= VALUE_BITS'(3);
      div_sq  <= SW'(9);
    end else if (cmd.advance) begin
      divisor <= divisor + VALUE_BITS'(2);
      // (d+2)^2 = d^2 + 4d + 4
      div_sq  <= div_sq + {divisor, 2'b00} + SW'(4);
    end

    if (cmd.div_start) begin
      rem      <= '0;
      dividend <= value;
      cnt      <= CW'(VALUE_BITS);
    end else if (cmd.div_step) begin
      rem      <= trial[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      dividend <= {dividend[VALUE_BITS-2:0], 1'b0};
      cnt      <= cnt - CW'(1);
    end

    if (cmd.set_flag) begin
      flag <= cmd.flag_val;
    end
  end

  // Status back to the controller
  always_comb begin
    status.below_two = (value < VALUE_BITS'(2));
    status.even      = ~value[0];
    status.is_two    = (value == VALUE_BITS'(2));
    status.bound_hit = (div_sq > {2'b00, value});
    status.div_last  = (cnt == CW'(1));
    status.rem_zero  = (rem == '0);
  end

  assign tested_number = value;
  assign prime_flag    = flag;

endmodule

@@ sv/tdpt_ctrl.sv @@
// Controller state machine: sequences the checks, divisions and the result strobe.
module tdpt_ctrl import tdpt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  tdpt_status_t status,
  output tdpt_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  tdpt_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    done         = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      // Small and even values settle at once
      ST_CHECK: begin
        if (status.below_two) begin
          cmd.set_flag = 1'b1;
          cmd.flag_val = 1'b0;
          state_next   = ST_DONE;
        end else if (status.even) begin
          cmd.set_flag = 1'b1;
          cmd.flag_val = status.is_two;
          state_next   = ST_DONE;
        end else begin
          state_next = ST_TEST;
        end
      end
      // Stop once the divisor squared passes the value
      ST_TEST: begin
        if (status.bound_hit) begin
          cmd.set_flag = 1'b1;
          cmd.flag_val = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EVAL;
        end
      end
      // Exact divisor found means composite, else try the next odd divisor
      ST_EVAL: begin
        if (status.rem_zero) begin
          cmd.set_flag = 1'b1;
          cmd.flag_val = 1'b0;
          state_next   = ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = ST_TEST;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ bench/tb_trial_division_prime_test.sv @@
// Testbench for the trial-division prime test: bursty requests, scoreboard check of each result.
module tb_trial_division_prime_test;

  localparam int VB = 31;
  // Random values are kept to at most this many odd trial divisors to bound run length
  localparam int MAX_RANDOM_TRIES = 150;
  localparam int RANDOM_ITEMS = 100;
  localparam int REPORT_LIMIT = 10;

  typedef logic [VB-1:0] value_t;

  // Expected result of one request
  typedef struct {
    value_t number;
    logic   flag;
  } prime_result_t;

  // Scoreboard: predicts the flag for each accepted request, checks results in order
  class prime_scoreboard;
    prime_result_t awaited[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Odd divisors from three while d <= v / d; tries counts divisors tested
    static function bit primality(value_t v, output int tries);
      longint unsigned x;
      longint unsigned d;
      tries = 0;
      x = 64'(v);
      if (x < 2) return 1'b0;
      if (x[0] == 1'b0) return x == 2;
      for (d = 3; d <= x / d; d += 2) begin
        tries++;
        if (x % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    function void note_request(value_t n);
      prime_result_t r;
      int tries;
      r.number = n;
      r.flag = primality(n, tries);
      awaited.insert(awaited.size(), r);
    endfunction

    function void check_result(logic [VB-1:0] n, logic f);
      prime_result_t r;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing pending: number=%0d flag=%b", n, f));
        return;
      end
      r = awaited.pop_front();
      if (n !== r.number)
        report($sformatf("tested_number expected %0d got %0d", r.number, n));
      if (f !== r.flag)
        report($sformatf("prime_flag for %0d expected %b got %b", r.number, r.flag, f));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  value_t       number = '0;
  logic         busy;
  logic         done;
  value_t       tested_number;
  logic         prime_flag;

  prime_scoreboard sb;
  int burst_left = 0;

  trial_division_prime_test #(.VALUE_BITS(VB)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .number        (number),
    .busy          (busy),
    .done          (done),
    .tested_number (tested_number),
    .prime_flag    (prime_flag)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result monitor: done is a one-cycle strobe, sampled at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(tested_number, prime_flag);
  end

  // Hold a request until the block takes it; called right after clk rises
  task automatic send_request(value_t v);
    start <= 1'b1;
    number <= v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(v);
  endtask

  // Idle gap with noise on the data port
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) begin
      number <= value_t'($urandom());
      @(posedge clk);
    end
  endtask

  // Bursts of back-to-back requests, usually separated by random gaps
  task automatic issue(value_t v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 40));
    end
    burst_left--;
    send_request(v);
  endtask

  // Random value, mostly cheap to test; mixes small, full-range, products, squares, near-top
  function automatic value_t pick_number();
    value_t v;
    longint unsigned a;
    longint unsigned b;
    int tries;
    do begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = value_t'($urandom_range(0, 2000));
        4, 5, 6:    v = value_t'($urandom());
        7: begin
          a = 64'($urandom_range(3, 99) | 1);
          b = 64'($urandom_range(1, 32'(32'h7FFF_FFFF / a)));
          v = value_t'(a * b);
        end
        8: begin
          a = 64'($urandom_range(2, 300));
          v = value_t'(a * a);
        end
        default: v = '1 - value_t'($urandom_range(0, 1000));
      endcase
      void'(prime_scoreboard::primality(v, tries));
    end while (tries > MAX_RANDOM_TRIES);
    return v;
  endfunction

  // Main sequence
  initial begin
    value_t directed[$];
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero, one, two, small odds and evens, squares at the divisor bound, field extremes
    directed = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd7, 31'd8, 31'd9,
                 31'd15, 31'd25, 31'd49, 31'd97, 31'd121, 31'd65537, 31'd1018081,
                 31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAB, 31'd2147483645,
                 31'd2147483646, 31'd2147483647};
    foreach (directed[i]) issue(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) issue(pick_number());

    // Drain
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
